FILE: design/tesw_pkg.sv
// shared types and constants for the text escape stream writer
// no dependencies; imported by every module of the block
`default_nettype none

package tesw_pkg;

  // escape and end bytes of the message stream
  localparam logic [7:0] ESC_ATTR   = 8'h15;
  localparam logic [7:0] ESC_CURSOR = 8'h16;
  localparam logic [7:0] END_BYTE   = 8'h00;

  localparam logic [7:0] LINE_WIDTH_RESET = 8'd53;

  // width of the cell address field on the result channel
  localparam int OUT_ADDR_W = 11;

  // command queue between parser and executor
  localparam int QDEPTH = 2;

  // parser phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ATTR = 4'b0010,
    PH_COL  = 4'b0100,
    PH_ROW  = 4'b1000
  } phase_t;

  // commands the parser hands to the executor
  typedef enum logic [1:0] {
    OP_CHAR   = 2'd0,
    OP_ATTR   = 2'd1,
    OP_CURSOR = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;    // character, attribute or row
    logic [7:0] column;  // column, cursor command only
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } queue_push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

`default_nettype wire

FILE: design/tesw_if.sv
// channel interfaces: message bytes in, cell writes out, line width writes
// depends on nothing
`default_nettype none

interface tesw_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  modport source (output valid, output msg_byte, input ready);
  modport sink   (input valid, input msg_byte, output ready);
endinterface

interface tesw_cell_if;
  logic        valid;
  logic        ready;
  logic [10:0] cell_address;
  logic [7:0]  char_code;
  logic [7:0]  cell_attr;
  modport source (output valid, output cell_address, output char_code, output cell_attr,
                  input ready);
  modport sink   (input valid, input cell_address, input char_code, input cell_attr,
                  output ready);
endinterface

interface tesw_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_width;
  modport source (output valid, output line_width, input ready);
  modport sink   (input valid, input line_width, output ready);
endinterface

`default_nettype wire

FILE: design/tesw_front.sv
// message parser: tracks escape phase, turns bytes into commands
// depends on tesw_pkg and tesw_msg_if
`default_nettype none

module tesw_front
  import tesw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  tesw_msg_if.sink     msg,
  input  wire logic    q_full,
  output queue_push_t  q_push
);

  phase_t     phase, phase_next;
  logic [7:0] column, column_next;
  logic       accept;

  assign msg.ready = !q_full;
  assign accept    = msg.valid && !q_full;

  always_comb begin
    phase_next       = phase;
    column_next      = column;
    q_push.push      = 1'b0;
    q_push.cmd.op    = OP_CHAR;
    q_push.cmd.data  = msg.msg_byte;
    q_push.cmd.column = column;
    if (accept) begin
      unique case (phase)
        PH_ATTR: begin
          q_push.push   = 1'b1;
          q_push.cmd.op = OP_ATTR;
          phase_next    = PH_IDLE;
        end
        PH_COL: begin
          column_next = msg.msg_byte;
          phase_next  = PH_ROW;
        end
        PH_ROW: begin
          q_push.push   = 1'b1;
          q_push.cmd.op = OP_CURSOR;
          phase_next    = PH_IDLE;
        end
        PH_IDLE: begin
          priority if (msg.msg_byte == ESC_ATTR) begin
            phase_next = PH_ATTR;
          end else if (msg.msg_byte == ESC_CURSOR) begin
            phase_next = PH_COL;
          end else if (msg.msg_byte == END_BYTE) begin
            phase_next = PH_IDLE;
          end else begin
            q_push.push = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      column <= '0;
    end else begin
      phase  <= phase_next;
      column <= column_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/tesw_queue.sv
// short command queue between parser and executor
// depends on tesw_pkg
`default_nettype none

module tesw_queue
  import tesw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire queue_push_t q_push,
  input  wire logic        pop,
  output logic             full,
  output queue_head_t      head
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = (count == CNT_W'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];
  assign do_push    = q_push.push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/tesw_back.sv
// executor: holds cursor, attribute and line width, drives the cell write register
// depends on tesw_pkg, tesw_cell_if and tesw_cfg_if
`default_nettype none

module tesw_back
  import tesw_pkg::*;
#(
  parameter int ADDR_BITS = 11
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire queue_head_t head,
  output logic             pop,
  tesw_cfg_if.sink         cfg,
  tesw_cell_if.source      screen
);

  localparam int PROD_W = 17;
  localparam int EXT_W  = (ADDR_BITS > OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;

  logic [7:0]           line_width;
  logic [ADDR_BITS-1:0] cursor, cursor_next;
  logic [7:0]           attr;
  logic                 out_valid, out_free;
  logic [PROD_W-1:0]    place;
  logic [EXT_W-1:0]     addr_ext;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
    end else if (cfg.valid) begin
      line_width <= cfg.line_width;
    end
  end

  assign out_free = !out_valid || screen.ready;
  assign pop      = head.valid && ((head.cmd.op != OP_CHAR) || out_free);

  // row * width + column - 1, wrapped to the cursor width
  assign place = PROD_W'(head.cmd.data) * PROD_W'(line_width) + PROD_W'(head.cmd.column)
               - PROD_W'(1);

  always_comb begin
    cursor_next = cursor;
    if (pop) begin
      unique case (head.cmd.op)
        OP_CHAR:   cursor_next = cursor + ADDR_BITS'(1);
        OP_CURSOR: cursor_next = place[ADDR_BITS-1:0];
        OP_ATTR:   cursor_next = cursor;
        default:   cursor_next = cursor;
      endcase
    end
  end

  assign addr_ext = EXT_W'(cursor_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      attr      <= '0;
      out_valid <= 1'b0;
    end else begin
      cursor <= cursor_next;
      if (pop && (head.cmd.op == OP_ATTR)) begin
        attr <= head.cmd.data;
      end
      if (out_free) begin
        out_valid <= pop && (head.cmd.op == OP_CHAR);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head.cmd.op == OP_CHAR)) begin
      screen.cell_address <= addr_ext[OUT_ADDR_W-1:0];
      screen.char_code    <= head.cmd.data;
      screen.cell_attr    <= attr;
    end
  end

  assign screen.valid = out_valid;

endmodule

`default_nettype wire

FILE: design/text_escape_stream_writer.sv
// top level of the text escape stream writer
// depends on tesw_pkg, tesw_if, tesw_front, tesw_queue and tesw_back
`default_nettype none

// Turns a message byte stream into character-cell writes for a text screen.
// Byte 0x15 makes the next byte the current attribute; byte 0x16 takes the
// next two bytes as column and row and moves the cursor to
// row*line_width+column-1 (wrapped to ADDR_BITS bits); byte 0 ends the
// message. Any other byte advances the cursor by one and comes out as one
// cell write of that character with the current attribute. One byte is
// accepted per cycle as long as the two-entry command queue has room; a
// character is written to the queue at its input transfer and, when the queue
// was empty and the output register free, moves to that register at the next
// edge, raising screen valid. Sustained throughput is one byte per cycle while
// the receiver keeps up, set by the executor taking one command per cycle.
// When the receiver holds off, the output register and the two queue entries
// fill and input then stalls. The user must write line_width through cfg only
// while the block is idle; the block itself does not enforce this.

module text_escape_stream_writer
  import tesw_pkg::*;
#(
  parameter int ADDR_BITS = 11
) (
  input  wire logic   clk,
  input  wire logic   rst,
  tesw_msg_if.sink    msg,
  tesw_cfg_if.sink    cfg,
  tesw_cell_if.source screen
);

  // parser to queue
  queue_push_t q_push;
  logic        q_full;

  // queue to executor
  queue_head_t q_head;
  logic        q_pop;

  // front: escape phase tracking and command building
  tesw_front u_front (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg),
    .q_full (q_full),
    .q_push (q_push)
  );

  // decouples parsing from output stalls
  tesw_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .pop    (q_pop),
    .full   (q_full),
    .head   (q_head)
  );

  // back: cursor and attribute update, cell write register
  tesw_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .pop    (q_pop),
    .cfg    (cfg),
    .screen (screen)
  );

endmodule

`default_nettype wire

FILE: tb/text_escape_stream_writer_tb.sv
// testbench for text_escape_stream_writer: message bytes in, cell writes checked out
// depends on tesw_pkg, tesw_if and the design sources of the block
`timescale 1ns / 1ps

module text_escape_stream_writer_tb;
  import tesw_pkg::*;

  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off for the pressure test
  localparam int SETTLE_CYCLES  = 6;     // cursor commands may still sit in the queue
  localparam int TAIL_CYCLES    = 10;
  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transfer
  localparam int RANDOM_ITEMS   = 1000;

  // one expected cell write
  typedef struct {
    logic [10:0] cell_address;
    logic [7:0]  char_code;
    logic [7:0]  cell_attr;
  } cell_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tesw_msg_if  msg_ch ();
  tesw_cfg_if  cfg_ch ();
  tesw_cell_if cell_ch ();

  text_escape_stream_writer #(
    .ADDR_BITS(11)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .msg   (msg_ch),
    .cfg   (cfg_ch),
    .screen(cell_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // screen model state, mirrors what the block should hold
  phase_t      parse_ph;
  logic [7:0]  column_hold;
  logic [10:0] cursor;
  logic [7:0]  attr_cur;
  logic [7:0]  line_width_cur;

  cell_write_t expected_writes[$];

  int n_items;
  int n_writes;
  int n_errors;
  int n_width_writes;

  // knobs shared between the stimulus and the receiver process
  bit tx_throttle;
  bit rx_throttle;
  int rx_hold_req;
  bit rx_holding;

  // advance the screen model by one accepted message byte
  function automatic void parse_msg_byte(input logic [7:0] b);
    logic [31:0] addr_sum;
    cell_write_t wr;
    case (parse_ph)
      PH_ATTR: begin
        attr_cur = b;
        parse_ph = PH_IDLE;
      end
      PH_COL: begin
        column_hold = b;
        parse_ph    = PH_ROW;
      end
      PH_ROW: begin
        // row*width + column - 1, column zero wraps below zero
        addr_sum = 32'(b) * 32'(line_width_cur) + 32'(column_hold) - 32'd1;
        cursor   = addr_sum[10:0];
        parse_ph = PH_IDLE;
      end
      default: begin
        if (b == ESC_ATTR) begin
          parse_ph = PH_ATTR;
        end else if (b == ESC_CURSOR) begin
          parse_ph = PH_COL;
        end else if (b == END_BYTE) begin
          parse_ph = PH_IDLE;
        end else begin
          // pre-increment, then write at the new cursor
          cursor          = cursor + 11'd1;
          wr.cell_address = cursor;
          wr.char_code    = b;
          wr.cell_attr    = attr_cur;
          expected_writes.push_back(wr);
        end
      end
    endcase
  endfunction

  // sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (!tx_throttle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // offer one byte and wait for its transfer; valid stays high on return so
  // back-to-back bytes need no dip in valid
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_ch.valid    <= 1'b1;
    msg_ch.msg_byte <= b;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    parse_msg_byte(b);
    n_items++;
  endtask

  // stop offering bytes and wait until every expected write has come out
  task automatic drain_writes();
    msg_ch.valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
  endtask

  // line width writes only once the block has gone quiet
  task automatic set_line_width(input logic [7:0] w);
    drain_writes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.line_width <= w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid   <= 1'b0;
    line_width_cur  = w;
    n_width_writes++;
  endtask

  task automatic send_cursor(input logic [7:0] col, input logic [7:0] row);
    send_byte(ESC_CURSOR);
    send_byte(col);
    send_byte(row);
  endtask

  // well-formed message: optional attribute, optional cursor move, text, end byte
  task automatic send_message();
    int         n_chars;
    logic [7:0] c;
    logic [7:0] col;
    logic [7:0] row;
    if ($urandom_range(0, 2) == 0) begin
      send_byte(ESC_ATTR);
      send_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1) == 0) begin
      col = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      row = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 40));
      send_cursor(col, row);
    end
    n_chars = $urandom_range(1, 12);
    repeat (n_chars) begin
      do c = 8'($urandom_range(1, 255));
      while (c == ESC_ATTR || c == ESC_CURSOR);
      send_byte(c);
    end
    send_byte(END_BYTE);
  endtask

  // noise: arbitrary bytes, which can leave an escape cut short
  task automatic send_noise();
    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_width();
    case ($urandom_range(0, 5))
      0:       return 8'd1;
      1:       return 8'd255;
      2:       return 8'd0;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // extremes of the byte, both escapes with odd operands, end byte while idle,
  // column zero wrap and address overflow, all at the reset line width
  task automatic test_directed();
    tx_throttle = 1'b0;
    rx_throttle = 1'b0;
    send_byte(8'h41);
    send_byte(8'hff);
    send_byte(8'h01);
    send_byte(ESC_ATTR);
    send_byte(8'hff);
    send_byte(8'h80);
    // attribute operands that look like end and escape bytes
    send_byte(ESC_ATTR);
    send_byte(END_BYTE);
    send_byte(ESC_ATTR);
    send_byte(ESC_ATTR);
    send_byte(ESC_ATTR);
    send_byte(ESC_CURSOR);
    // column zero, row zero: cursor lands at the top of the address space
    send_cursor(8'd0, 8'd0);
    send_byte(8'h42);
    // escape values as column and row
    send_cursor(ESC_CURSOR, ESC_ATTR);
    // largest column and row overflow the address
    send_cursor(8'hff, 8'hff);
    send_byte(8'h43);
    send_byte(END_BYTE);
    send_byte(8'h7f);
    drain_writes();
  endtask

  // cursor math across the line width range, zero and the extremes included
  task automatic test_line_width();
    logic [7:0] widths[5];
    widths = '{8'd1, 8'd255, 8'd0, 8'd127, LINE_WIDTH_RESET};
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
    foreach (widths[i]) begin
      set_line_width(widths[i]);
      send_cursor(8'hff, 8'hff);
      send_byte(8'h5a);
      send_cursor(8'd0, 8'($urandom_range(0, 255)));
      send_byte(8'h61);
      send_cursor(8'($urandom_range(0, 255)), 8'($urandom_range(0, 40)));
      send_byte(8'h62);
      send_byte(END_BYTE);
    end
    drain_writes();
  endtask

  // receiver holds off for a long stretch while bytes keep coming, so the
  // queue fills and input stalls; then the sender waits for every write
  task automatic test_backpressure();
    tx_throttle = 1'b0;
    rx_throttle = 1'b0;
    drain_writes();
    rx_hold_req = HOLD_CYCLES;
    while (!rx_holding) @(posedge clk);
    send_cursor(8'd3, 8'd2);
    for (int i = 0; i < 40; i++) send_byte(8'(8'h30 + i));
    send_byte(END_BYTE);
    drain_writes();
  endtask

  // mostly well-formed messages with random content, some noise, with the
  // idle knobs and the line width changing along the way
  task automatic test_random();
    int start_items;
    int next_width_at;
    int msg_count;
    start_items   = n_items;
    next_width_at = n_items + 250;
    msg_count     = 0;
    while (n_items - start_items < RANDOM_ITEMS) begin
      if (msg_count % 20 == 0) begin
        tx_throttle = ($urandom_range(0, 3) != 0);
        rx_throttle = ($urandom_range(0, 3) != 0);
      end
      if (n_items >= next_width_at) begin
        set_line_width(pick_width());
        next_width_at = n_items + 250;
      end
      if ($urandom_range(0, 99) < 85) send_message();
      else send_noise();
      msg_count++;
    end
    drain_writes();
  endtask

  // receiver: stalls of random length, or one long hold-off when asked
  initial begin : rx_stall
    int run_len;
    bit rdy;
    int r;
    cell_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      rx_holding = 1'b0;
      if (rx_hold_req > 0) begin
        rdy         = 1'b0;
        run_len     = rx_hold_req;
        rx_hold_req = 0;
        rx_holding  = 1'b1;
      end else if (!rx_throttle) begin
        rdy     = 1'b1;
        run_len = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          rdy     = 1'b1;
          run_len = $urandom_range(1, 8);
        end else if (r < 92) begin
          rdy     = 1'b0;
          run_len = $urandom_range(1, 3);
        end else begin
          rdy     = 1'b0;
          run_len = $urandom_range(10, 40);
        end
      end
      cell_ch.ready <= rdy;
      repeat (run_len) @(posedge clk);
    end
  end

  // each cell write transfer against the oldest expected write
  always @(posedge clk) begin
    cell_write_t wr;
    if (!rst && cell_ch.valid && cell_ch.ready) begin
      if (expected_writes.size() == 0) begin
        $error("cell write with nothing expected: address %0h char %0h attr %0h",
               cell_ch.cell_address, cell_ch.char_code, cell_ch.cell_attr);
        n_errors++;
      end else begin
        wr = expected_writes.pop_front();
        n_writes++;
        if (cell_ch.cell_address !== wr.cell_address) begin
          $error("cell_address: expected %0h, got %0h", wr.cell_address,
                 cell_ch.cell_address);
          n_errors++;
        end
        if (cell_ch.char_code !== wr.char_code) begin
          $error("char_code: expected %0h, got %0h", wr.char_code, cell_ch.char_code);
          n_errors++;
        end
        if (cell_ch.cell_attr !== wr.cell_attr) begin
          $error("cell_attr: expected %0h, got %0h", wr.cell_attr, cell_ch.cell_attr);
          n_errors++;
        end
      end
    end
  end

  // watchdog: too long with no transfer on any channel ends the run
  always @(posedge clk) begin
    int quiet_cycles;
    if (rst || (msg_ch.valid && msg_ch.ready) || (cell_ch.valid && cell_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: %0d writes still expected", expected_writes.size());
        $display("text_escape_stream_writer_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    msg_ch.valid      <= 1'b0;
    msg_ch.msg_byte   <= 8'h00;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.line_width <= LINE_WIDTH_RESET;
    parse_ph       = PH_IDLE;
    column_hold    = 8'h00;
    cursor         = 11'd0;
    attr_cur       = 8'h00;
    line_width_cur = LINE_WIDTH_RESET;
    n_items        = 0;
    n_writes       = 0;
    n_errors       = 0;
    n_width_writes = 0;
    tx_throttle    = 1'b0;
    rx_throttle    = 1'b0;
    rx_hold_req    = 0;
    rx_holding     = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_line_width();
    test_backpressure();
    test_random();

    drain_writes();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d message bytes, %0d cell writes checked, %0d line width changes",
             n_items, n_writes, n_width_writes);
    $display("escapes, end bytes, cursor wrap, long receiver hold-off and random stalls");
    if (n_errors == 0 && expected_writes.size() == 0) begin
      $display("text_escape_stream_writer_tb OK");
    end else begin
      $display("%0d mismatches, %0d writes never seen", n_errors, expected_writes.size());
      $display("text_escape_stream_writer_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/tesw_pkg.sv
design/tesw_if.sv
design/tesw_front.sv
design/tesw_queue.sv
design/tesw_back.sv
design/text_escape_stream_writer.sv
tb/text_escape_stream_writer_tb.sv
